### hw/rtl/tkt_pkg.sv
// Package for the top-K tracker: sizes, op codes and the command struct
// that the top level broadcasts to every list cell. No dependencies.
`default_nettype none

package tkt_pkg;

  localparam int unsigned CAPACITY = 8;
  localparam int unsigned ValW     = 32;
  localparam int unsigned TagW     = 32;
  localparam int unsigned RankW    = 3;
  localparam int unsigned OpW      = 2;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned SlotW    = $clog2(CAPACITY);
  localparam int unsigned CmpW     = (CntW > RankW) ? CntW : RankW;
  localparam int unsigned CountW   = 4;

  localparam logic [TagW-1:0] TagNone = {TagW{1'b1}};

  localparam logic [OpW-1:0] OpAdd   = 2'd0;
  localparam logic [OpW-1:0] OpFill  = 2'd1;
  localparam logic [OpW-1:0] OpClear = 2'd2;
  localparam logic [OpW-1:0] OpRead  = 2'd3;

  // Command seen by every cell in the cycle an item is transferred.
  typedef struct packed {
    logic                   grow;    // add while not full
    logic                   evict;   // add into a full list, accepted
    logic                   fill;    // load every slot
    logic signed [ValW-1:0] value;
    logic        [TagW-1:0] tag;
  } cell_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/tkt_cell.sv
// One slot of the ascending list: holds a value and a tag, compares the value
// with the incoming sample and shifts with its neighbors. Uses tkt_pkg.
`default_nettype none

module tkt_cell (
  input  wire logic                          clk_i,
  input  wire tkt_pkg::cell_cmd_t            cmd_i,
  input  wire logic                          occ_i,      // slot below count
  input  wire logic                          at_tail_i,  // slot index == count
  input  wire logic                          left_gt_i,
  input  wire logic signed [tkt_pkg::ValW-1:0] left_val_i,
  input  wire logic        [tkt_pkg::TagW-1:0] left_tag_i,
  input  wire logic                          right_lt_i,
  input  wire logic signed [tkt_pkg::ValW-1:0] right_val_i,
  input  wire logic        [tkt_pkg::TagW-1:0] right_tag_i,
  output logic                               gt_o,
  output logic                               lt_o,
  output logic signed [tkt_pkg::ValW-1:0]    val_o,
  output logic        [tkt_pkg::TagW-1:0]    tag_o
);
  import tkt_pkg::*;

  logic signed [ValW-1:0] val_q, val_d;
  logic        [TagW-1:0] tag_q, tag_d;

  assign gt_o = occ_i && (val_q > cmd_i.value);
  assign lt_o = (val_q < cmd_i.value);

  always_comb begin
    val_d = val_q;
    tag_d = tag_q;
    if (cmd_i.fill) begin
      val_d = cmd_i.value;
      tag_d = cmd_i.tag;
    end else if (cmd_i.grow) begin
      // shift up past larger entries, insert after equals
      if (left_gt_i) begin
        val_d = left_val_i;
        tag_d = left_tag_i;
      end else if (gt_o || at_tail_i) begin
        val_d = cmd_i.value;
        tag_d = cmd_i.tag;
      end
    end else if (cmd_i.evict) begin
      // drop the smallest, shift down past smaller entries
      if (right_lt_i) begin
        val_d = right_val_i;
        tag_d = right_tag_i;
      end else if (lt_o) begin
        val_d = cmd_i.value;
        tag_d = cmd_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    tag_q <= tag_d;
  end

  assign val_o = val_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

### hw/rtl/top_k_max_tracker_with_tags_top.sv
// Top level of the top-K tracker: a row of tkt_cell slots, the entry count,
// the rank read mux and the output register. Uses tkt_pkg and tkt_cell.
//
// Usage:
//   Input stream (s_axis_*): one transfer per command. tuser carries the op
//   (add, fill all, clear, read by rank); tdata carries value, tag and rank.
//   Output stream (m_axis_*): exactly one result transfer per command, in
//   order, with accepted, read_valid, read_value, read_tag and entry_count.
//   The list is a row of compare-and-shift cells, one per slot, held in
//   ascending order; an add or fill updates every cell in the same cycle
//   the command is transferred.
//   The result is registered and shown in the cycle after the input transfer.
//   Throughput: one command per cycle while the receiver takes results,
//   set by the single output register; s_axis_tready is high when that
//   register is empty or being emptied in the same cycle.
//   Reset empties the list (count 0) and drops any pending result; slot
//   contents are not cleared, since only slots below the count are read.
//   When the receiver stalls, the result holds and input stalls with it.
`default_nettype none

module top_k_max_tracker_with_tags_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: [31:0] sample_value, [63:32] sample_tag, [66:64] rank, rest zero
  input  wire logic [71:0] s_axis_tdata,
  // tuser: [1:0] op
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: [0] accepted, [1] read_valid, [33:2] read_value,
  //        [65:34] read_tag, [69:66] entry_count, rest zero
  output logic [71:0]      m_axis_tdata
);
  import tkt_pkg::*;

  // Unpack the input transfer
  logic        [OpW-1:0]   op;
  logic signed [ValW-1:0]  sample_value;
  logic        [TagW-1:0]  sample_tag;
  logic        [RankW-1:0] rank;

  assign op           = s_axis_tuser;
  assign sample_value = s_axis_tdata[31:0];
  assign sample_tag   = s_axis_tdata[63:32];
  assign rank         = s_axis_tdata[66:64];

  logic in_xfer;
  logic out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  logic [CntW-1:0] count_q, count_d;
  logic            full;

  assign full = (count_q == CntW'(CAPACITY));

  // Cell row wiring
  logic                   cell_gt  [CAPACITY];
  logic                   cell_lt  [CAPACITY];
  logic signed [ValW-1:0] cell_val [CAPACITY];
  logic        [TagW-1:0] cell_tag [CAPACITY];

  cell_cmd_t cmd;
  logic      evict_ok;

  // A full-list add goes in only when strictly above the smallest entry
  assign evict_ok = cell_lt[0];

  always_comb begin
    cmd.grow  = in_xfer && (op == OpAdd) && !full;
    cmd.evict = in_xfer && (op == OpAdd) && full && evict_ok;
    cmd.fill  = in_xfer && (op == OpFill);
    cmd.value = sample_value;
    cmd.tag   = sample_tag;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   left_gt, right_lt;
    logic signed [ValW-1:0] left_val, right_val;
    logic        [TagW-1:0] left_tag, right_tag;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_val = '0;
      assign left_tag = '0;
    end else begin : g_mid_l
      assign left_gt  = cell_gt[i-1];
      assign left_val = cell_val[i-1];
      assign left_tag = cell_tag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_lt  = 1'b0;
      assign right_val = '0;
      assign right_tag = '0;
    end else begin : g_mid_r
      assign right_lt  = cell_lt[i+1];
      assign right_val = cell_val[i+1];
      assign right_tag = cell_tag[i+1];
    end

    tkt_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occ_i      (count_q > CntW'(i)),
      .at_tail_i  (count_q == CntW'(i)),
      .left_gt_i  (left_gt),
      .left_val_i (left_val),
      .left_tag_i (left_tag),
      .right_lt_i (right_lt),
      .right_val_i(right_val),
      .right_tag_i(right_tag),
      .gt_o       (cell_gt[i]),
      .lt_o       (cell_lt[i]),
      .val_o      (cell_val[i]),
      .tag_o      (cell_tag[i])
    );
  end

  // Entry count
  always_comb begin
    count_d = count_q;
    if (in_xfer) begin
      unique case (op)
        OpAdd:   if (!full) count_d = count_q + CntW'(1);
        OpFill:  count_d = CntW'(CAPACITY);
        OpClear: count_d = '0;
        OpRead:  count_d = count_q;
        default: count_d = count_q;
      endcase
    end
  end

  // Rank read: rank 0 is the top slot below the count
  logic            rd_hit;
  logic [CntW-1:0] rd_slot;

  assign rd_hit  = (CmpW'(rank) < CmpW'(count_q));
  assign rd_slot = count_q - CntW'(1) - CntW'(rank);

  // Result register
  logic                   acc_q;
  logic                   rvalid_q;
  logic signed [ValW-1:0] rval_q;
  logic        [TagW-1:0] rtag_q;
  logic [CountW-1:0]      ecount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      acc_q    <= cmd.grow || cmd.evict || cmd.fill;
      rvalid_q <= (op == OpRead) && rd_hit;
      if ((op == OpRead) && rd_hit) begin
        rval_q <= cell_val[rd_slot[SlotW-1:0]];
        rtag_q <= cell_tag[rd_slot[SlotW-1:0]];
      end else begin
        rval_q <= '0;
        rtag_q <= TagNone;
      end
      ecount_q <= CountW'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, ecount_q, rtag_q, rval_q, rvalid_q, acc_q};

endmodule

`default_nettype wire
